// ===== rtl/pswt_pkg.sv =====
// ----------------------------------------------------------------------------
// pswt_pkg
// Shared widths, job entry type and the command and status groups that pass
// between the controller and the datapath of the priority scheduler.
// ----------------------------------------------------------------------------
package pswt_pkg;

  localparam int MAX_PROCS = 32;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int ID_W      = 6;
  localparam int TIME_W    = 21;
  localparam int TOTAL_W   = 26;
  localparam int STEP_W    = $clog2(TOTAL_W);
  localparam int REM_W     = CNT_W + 1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } pswt_entry_t;

  localparam int ENTRY_W = $bits(pswt_entry_t);

  // write data select
  localparam logic [1:0] WSEL_LOAD  = 2'd0;
  localparam logic [1:0] WSEL_BEST  = 2'd1;
  localparam logic [1:0] WSEL_FIRST = 2'd2;

  typedef struct packed {
    logic              ram_we;
    logic [1:0]        wsel;
    logic [IDX_W-1:0]  waddr;
    logic [ID_W-1:0]   load_id;
    logic              rd_en;
    logic              rd_first;
    logic [IDX_W-1:0]  rd_addr;
    logic              emit_clear;
    logic              emit_calc;
    logic              emit_last;
    logic              dropped;
    logic              div_start;
    logic [CNT_W-1:0]  div_count;
    logic              out_finish;
  } pswt_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic div_done;
  } pswt_status_t;

endpackage

// ===== rtl/pswt_ram.sv =====
// ----------------------------------------------------------------------------
// pswt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pswt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pswt_div.sv =====
// ----------------------------------------------------------------------------
// pswt_div
// Restoring divider, one quotient bit per cycle, for the schedule averages.
// ----------------------------------------------------------------------------
module pswt_div import pswt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TOTAL_W-1:0] dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [TOTAL_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [TOTAL_W-1:0] quo;
  logic [CNT_W-1:0]  den;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign trial    = {rem[REM_W-2:0], quo[TOTAL_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(TOTAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, den}) : trial;
      quo <= {quo[TOTAL_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/pswt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pswt_ctrl
// Sequencer: job loading, selection sort passes, row emission and averaging.
// ----------------------------------------------------------------------------
module pswt_ctrl import pswt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         last_job,
  input  pswt_status_t status,
  output pswt_cmd_t    cmd
);

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_SEL       = 4'd1;
  localparam logic [3:0] ST_SCAN      = 4'd2;
  localparam logic [3:0] ST_SWAP_A    = 4'd3;
  localparam logic [3:0] ST_SWAP_B    = 4'd4;
  localparam logic [3:0] ST_EMIT_RD   = 4'd5;
  localparam logic [3:0] ST_EMIT_CALC = 4'd6;
  localparam logic [3:0] ST_DIV_GO    = 4'd7;
  localparam logic [3:0] ST_DIV_WAIT  = 4'd8;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] j, j_next;
  logic [CNT_W-1:0] k, k_next;
  logic             dropped, dropped_next;

  always_comb begin
    state_next   = state;
    count_next   = count;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    dropped_next = dropped;
    in_ready     = 1'b0;

    cmd            = '0;
    cmd.load_id    = ID_W'(count) + ID_W'(1);
    cmd.dropped    = dropped;
    cmd.div_count  = count;

    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count < CNT_W'(MAX_PROCS)) begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = WSEL_LOAD;
            cmd.waddr  = count[IDX_W-1:0];
            count_next = count + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (last_job) begin
            i_next     = '0;
            state_next = ST_SEL;
          end
        end
      end
      ST_SEL: begin
        if ((i + CNT_W'(1)) >= count) begin
          k_next         = '0;
          cmd.emit_clear = 1'b1;
          state_next     = ST_EMIT_RD;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_first = 1'b1;
          cmd.rd_addr  = i[IDX_W-1:0];
          j_next       = i + CNT_W'(1);
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j < count) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = j[IDX_W-1:0];
          j_next      = j + CNT_W'(1);
        end else begin
          state_next = ST_SWAP_A;
        end
      end
      ST_SWAP_A: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = WSEL_BEST;
        cmd.waddr  = i[IDX_W-1:0];
        state_next = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = WSEL_FIRST;
        i_next     = i + CNT_W'(1);
        state_next = ST_SEL;
      end
      ST_EMIT_RD: begin
        if (!status.out_busy) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = k[IDX_W-1:0];
          state_next  = ST_EMIT_CALC;
        end
      end
      ST_EMIT_CALC: begin
        cmd.emit_calc = 1'b1;
        cmd.emit_last = (k + CNT_W'(1)) == count;
        if (cmd.emit_last) begin
          state_next = ST_DIV_GO;
        end else begin
          k_next     = k + CNT_W'(1);
          state_next = ST_EMIT_RD;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.out_finish = 1'b1;
          count_next     = '0;
          dropped_next   = 1'b0;
          state_next     = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      i       <= i_next;
      j       <= j_next;
      k       <= k_next;
      dropped <= dropped_next;
    end
  end

endmodule

// ===== rtl/pswt_dpath.sv =====
// ----------------------------------------------------------------------------
// pswt_dpath
// Job store, minimum search registers, time accumulators, average dividers
// and the output row register.
// ----------------------------------------------------------------------------
module pswt_dpath import pswt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  pswt_cmd_t          cmd,
  output pswt_status_t       status,
  input  logic [BURST_W-1:0] burst_time,
  input  logic [PRIO_W-1:0]  priority_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    job_id,
  output logic [BURST_W-1:0] job_burst,
  output logic [TIME_W-1:0]  wait_time,
  output logic [TIME_W-1:0]  turnaround_time,
  output logic [TIME_W-1:0]  avg_wait,
  output logic [TIME_W-1:0]  avg_turnaround,
  output logic               overflow,
  output logic               last_row
);

  pswt_entry_t       rdata;
  logic [ENTRY_W-1:0] rdata_raw;
  pswt_entry_t       wdata;
  logic [IDX_W-1:0]  waddr;

  logic              rd_vld;
  logic              rd_first_q;
  logic [IDX_W-1:0]  rd_idx;
  pswt_entry_t       first;
  pswt_entry_t       best;
  logic [IDX_W-1:0]  best_idx;

  logic [TIME_W-1:0]  elapsed;
  logic [TOTAL_W-1:0] wait_total;
  logic [TOTAL_W-1:0] tat_total;
  logic [TIME_W-1:0]  row_tat;

  logic               done_w, done_t;
  logic [TOTAL_W-1:0] quo_w, quo_t;

  always_comb begin
    case (cmd.wsel)
      WSEL_LOAD:  wdata = '{id: cmd.load_id, prio: priority_value, burst: burst_time};
      WSEL_BEST:  wdata = best;
      WSEL_FIRST: wdata = first;
      default:    wdata = '{id: cmd.load_id, prio: priority_value, burst: burst_time};
    endcase
  end

  assign waddr   = (cmd.wsel == WSEL_FIRST) ? best_idx : cmd.waddr;
  assign rdata   = pswt_entry_t'(rdata_raw);
  assign row_tat = elapsed + TIME_W'(rdata.burst);

  pswt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata_raw)
  );

  pswt_div u_div_wait (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (wait_total),
    .divisor  (cmd.div_count),
    .done     (done_w),
    .quotient (quo_w)
  );

  pswt_div u_div_tat (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tat_total),
    .divisor  (cmd.div_count),
    .done     (done_t),
    .quotient (quo_t)
  );

  assign status.out_busy = out_valid;
  assign status.div_done = done_w & done_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if ((cmd.emit_calc && !cmd.emit_last) || cmd.out_finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // track the smallest priority of the current scan
  always_ff @(posedge clk) begin
    rd_first_q <= cmd.rd_first;
    rd_idx     <= cmd.rd_addr;
    if (rd_vld) begin
      if (rd_first_q) begin
        first    <= rdata;
        best     <= rdata;
        best_idx <= rd_idx;
      end else if (rdata.prio < best.prio) begin
        best     <= rdata;
        best_idx <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_clear) begin
      elapsed    <= '0;
      wait_total <= '0;
      tat_total  <= '0;
    end else if (cmd.emit_calc) begin
      elapsed    <= row_tat;
      wait_total <= wait_total + TOTAL_W'(elapsed);
      tat_total  <= tat_total + TOTAL_W'(row_tat);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_calc) begin
      job_id          <= rdata.id;
      job_burst       <= rdata.burst;
      wait_time       <= elapsed;
      turnaround_time <= row_tat;
      avg_wait        <= '0;
      avg_turnaround  <= '0;
      overflow        <= cmd.dropped;
      last_row        <= cmd.emit_last;
    end else if (cmd.out_finish) begin
      avg_wait       <= quo_w[TIME_W-1:0];
      avg_turnaround <= quo_t[TIME_W-1:0];
    end
  end

endmodule

// ===== rtl/priority_schedule_wait_times_unit.sv =====
// ----------------------------------------------------------------------------
// priority_schedule_wait_times_unit
// Non-preemptive priority scheduler: loads a job set, orders it by priority
// and emits one row per job with waiting and turnaround times.
// ----------------------------------------------------------------------------
// While a set loads, in_ready is high and each valid beat takes a job; jobs
// past the 32nd are dropped and flagged on every row. The last_job beat closes
// the set, and no job is taken again until the final row is in the output
// register. Ordering is a selection sort over a single-read job RAM: each pass
// reads entry i, scans the rest for the smallest priority and swaps the best
// entry into slot i. Each row passes from the RAM read register to the output
// register, and a row is only loaded once the previous one has been taken.
// Before the final row the two averages run through 26-bit restoring dividers,
// one quotient bit per cycle. The next set may load while the final row waits.
module priority_schedule_wait_times_unit import pswt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BURST_W-1:0] burst_time,
  input  logic [PRIO_W-1:0]  priority_value,
  input  logic               last_job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    job_id,
  output logic [BURST_W-1:0] job_burst,
  output logic [TIME_W-1:0]  wait_time,
  output logic [TIME_W-1:0]  turnaround_time,
  output logic [TIME_W-1:0]  avg_wait,
  output logic [TIME_W-1:0]  avg_turnaround,
  output logic               overflow,
  output logic               last_row
);

  pswt_cmd_t    cmd;
  pswt_status_t status;

  pswt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .last_job (last_job),
    .status   (status),
    .cmd      (cmd)
  );

  pswt_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .burst_time      (burst_time),
    .priority_value  (priority_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .job_id          (job_id),
    .job_burst       (job_burst),
    .wait_time       (wait_time),
    .turnaround_time (turnaround_time),
    .avg_wait        (avg_wait),
    .avg_turnaround  (avg_turnaround),
    .overflow        (overflow),
    .last_row        (last_row)
  );

  a_tat_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> turnaround_time == (wait_time + TIME_W'(job_burst)))
    else $error("turnaround differs from wait plus burst");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_row) |-> (avg_wait == '0 && avg_turnaround == '0))
    else $error("average shown on a row other than the last");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (job_id != '0 && job_id <= ID_W'(MAX_PROCS)))
    else $error("job id out of range");

  a_no_load_in_sort: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_job) |=> !in_ready)
    else $error("job taken while a set is being scheduled");

endmodule
